### src/hafr_pkg.sv
// Package for the async HDLC framer: step codes, config indices, queue entry type, byte
// constants and the FCS-16 byte update. No dependencies.
package hafr_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ADDR_BYTE = 8'hFF;
    localparam logic [7:0]  CTRL_BYTE = 8'h03;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] FCS_POLY  = 16'h8408;
    localparam logic [15:0] FCS_INIT  = 16'hFFFF;

    localparam logic [63:0] MAP0_RESET = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] MAP1_RESET = 64'h6000_0000_0000_0000;
    localparam logic [63:0] MAP2_RESET = 64'h0;
    localparam logic [63:0] MAP3_RESET = 64'h0;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP0 = 3'd0,
        CFG_MAP1 = 3'd1,
        CFG_MAP2 = 3'd2,
        CFG_MAP3 = 3'd3,
        CFG_CAC  = 3'd4
    } t_cfg_idx;

    // Position of the front sequencer within one input item
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLAG,
        ST_ADDR,
        ST_CTRL,
        ST_DATA,
        ST_FCS_LO,
        ST_FCS_HI,
        ST_CLOSE
    } t_step;

    // One queued symbol: unescaped byte plus its handling
    typedef struct packed {
        logic [7:0] line_byte;
        logic       esc;
        logic       run_last;
        logic       frame_done;
    } t_sym;

    // Reflected CRC-16 (0x8408) over one byte, LSB first
    function automatic logic [15:0] fcs_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] a;
        a = acc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (a[0]) begin
                a = (a >> 1) ^ FCS_POLY;
            end else begin
                a = a >> 1;
            end
        end
        return a;
    endfunction

endpackage

### src/hafr_if.sv
// Channel interfaces of the async HDLC framer: payload in, line bytes out, config writes.
// Depends on hafr_pkg for the config widths.
interface hafr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       frame_start;
    logic       frame_end;
    logic       is_lcp;

    modport source (output valid, payload_byte, frame_start, frame_end, is_lcp, input ready);
    modport sink   (input valid, payload_byte, frame_start, frame_end, is_lcp, output ready);
endinterface

interface hafr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_done;

    modport source (output valid, line_byte, run_last, frame_done, input ready);
    modport sink   (input valid, line_byte, run_last, frame_done, output ready);
endinterface

interface hafr_cfg_if import hafr_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/hafr_fifo.sv
// Small register queue of framer symbols between front and back.
// Depends on hafr_pkg for t_sym.
module hafr_fifo
    import hafr_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_sym i_sym,
    output logic o_full,
    input  logic i_pop,
    output t_sym o_sym,
    output logic o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    t_sym          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == DEPTH_C);
    assign o_empty = (r_count == '0);
    assign o_sym   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

### src/hafr_front.sv
// Front of the framer: holds config, sequences each input item into symbols,
// runs the FCS and classifies each symbol for escaping. Depends on hafr_pkg, hafr_if.
module hafr_front
    import hafr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    hafr_in_if.sink i_in,
    hafr_cfg_if.sink i_cfg,
    input  logic    i_full,
    output logic    o_push,
    output t_sym    o_sym
);
    logic [63:0] r_map [4];
    logic        r_cac;
    logic [15:0] r_fcs;
    logic        r_lcp;
    t_step       r_step;
    logic        r_have;
    logic [7:0]  r_data;
    logic        r_first;
    logic        r_last;
    logic        r_item_lcp;

    t_step       n_step;
    logic [15:0] n_fcs;
    logic        n_lcp;
    t_step       cur;
    logic        item_done;
    logic        go;
    logic        take;
    logic        esc_data;
    logic [7:0]  sym_byte;
    logic        sym_esc;
    logic        sym_last;
    logic        sym_done;

    assign i_cfg.ready = 1'b1;

    // Escape map and header compression
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map[0] <= MAP0_RESET;
            r_map[1] <= MAP1_RESET;
            r_map[2] <= MAP2_RESET;
            r_map[3] <= MAP3_RESET;
            r_cac    <= 1'b0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_MAP0: r_map[0] <= i_cfg.data;
                CFG_MAP1: r_map[1] <= i_cfg.data;
                CFG_MAP2: r_map[2] <= i_cfg.data;
                CFG_MAP3: r_map[3] <= i_cfg.data;
                CFG_CAC:  r_cac    <= i_cfg.data[0];
                default:  ;
            endcase
        end
    end

    // LCP forces control characters; otherwise the map decides
    always_comb begin
        esc_data = (r_lcp && (sym_byte < ESC_XOR)) || r_map[sym_byte[7:6]][sym_byte[5:0]];
    end

    always_comb begin
        cur       = (r_step == ST_IDLE) ? (r_first ? ST_FLAG : ST_DATA) : r_step;
        n_step    = r_step;
        n_fcs     = r_fcs;
        n_lcp     = r_lcp;
        item_done = 1'b0;
        sym_byte  = FLAG_BYTE;
        sym_esc   = 1'b0;
        sym_last  = 1'b0;
        sym_done  = 1'b0;
        case (cur)
            ST_FLAG: begin
                n_fcs  = FCS_INIT;
                n_lcp  = r_item_lcp;
                n_step = (r_item_lcp || !r_cac) ? ST_ADDR : ST_DATA;
            end
            ST_ADDR: begin
                sym_byte = ADDR_BYTE;
                sym_esc  = esc_data;
                n_fcs    = fcs_update(r_fcs, ADDR_BYTE);
                n_step   = ST_CTRL;
            end
            ST_CTRL: begin
                sym_byte = CTRL_BYTE;
                sym_esc  = esc_data;
                n_fcs    = fcs_update(r_fcs, CTRL_BYTE);
                n_step   = ST_DATA;
            end
            ST_DATA: begin
                sym_byte  = r_data;
                sym_esc   = esc_data;
                n_fcs     = fcs_update(r_fcs, r_data);
                sym_last  = !r_last;
                item_done = !r_last;
                n_step    = r_last ? ST_FCS_LO : ST_IDLE;
            end
            ST_FCS_LO: begin
                sym_byte = ~r_fcs[7:0];
                sym_esc  = esc_data;
                n_step   = ST_FCS_HI;
            end
            ST_FCS_HI: begin
                sym_byte = ~r_fcs[15:8];
                sym_esc  = esc_data;
                n_step   = ST_CLOSE;
            end
            ST_CLOSE: begin
                sym_last  = 1'b1;
                sym_done  = 1'b1;
                n_fcs     = FCS_INIT;
                item_done = 1'b1;
                n_step    = ST_IDLE;
            end
            default: begin
                n_step = ST_IDLE;
            end
        endcase
    end

    // Take a new beat when the item register is free or its last symbol leaves now
    assign go          = r_have && !i_full;
    assign i_in.ready  = !r_have || (go && item_done);
    assign take        = i_in.valid && i_in.ready;
    assign o_push      = go;
    assign o_sym       = '{line_byte: sym_byte, esc: sym_esc, run_last: sym_last,
                           frame_done: sym_done};

    // Accepted payload beat, held until its last symbol is queued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have     <= 1'b0;
            r_data     <= '0;
            r_first    <= 1'b0;
            r_last     <= 1'b0;
            r_item_lcp <= 1'b0;
        end else if (take) begin
            r_have     <= 1'b1;
            r_data     <= i_in.payload_byte;
            r_first    <= i_in.frame_start;
            r_last     <= i_in.frame_end;
            r_item_lcp <= i_in.is_lcp;
        end else if (go && item_done) begin
            r_have     <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
            r_fcs  <= FCS_INIT;
            r_lcp  <= 1'b0;
        end else if (go) begin
            r_step <= n_step;
            r_fcs  <= n_fcs;
            r_lcp  <= n_lcp;
        end
    end
endmodule

### src/hafr_back.sv
// Back of the framer: pops symbols, expands escaped ones into two line bytes
// and drives the output register. Depends on hafr_pkg, hafr_if.
module hafr_back
    import hafr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_sym        i_sym,
    output logic        o_pop,
    hafr_out_if.source  o_out
);
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_done;
    logic       r_pend;
    t_sym       r_hold;

    logic       n_valid;
    logic [7:0] n_byte;
    logic       n_last;
    logic       n_done;
    logic       n_pend;
    logic       load;

    assign load = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        n_done  = r_done;
        n_pend  = r_pend;
        o_pop   = 1'b0;
        if (load) begin
            if (r_pend) begin
                // second half of an escape pair
                n_valid = 1'b1;
                n_byte  = r_hold.line_byte ^ ESC_XOR;
                n_last  = r_hold.run_last;
                n_done  = r_hold.frame_done;
                n_pend  = 1'b0;
            end else if (!i_empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                if (i_sym.esc) begin
                    n_byte = ESC_BYTE;
                    n_last = 1'b0;
                    n_done = 1'b0;
                    n_pend = 1'b1;
                end else begin
                    n_byte = i_sym.line_byte;
                    n_last = i_sym.run_last;
                    n_done = i_sym.frame_done;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
        r_done <= n_done;
        if (o_pop) begin
            r_hold <= i_sym;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.line_byte  = r_byte;
    assign o_out.run_last   = r_last;
    assign o_out.frame_done = r_done;
endmodule

### src/hdlc_async_framer_top.sv
// Async HDLC (PPP) framer: an accepted payload beat is held in the front's item register,
// passes the symbol queue and leaves through the single output register in the back end;
// the line side moves one beat per cycle unless the line stalls, one per line byte.
// The front registers each beat, then emits one symbol per cycle while the queue is not full, so it keeps ahead.
// Reset (synchronous, active low) empties the queue, restores the escape map and
// header mode to defaults, FCS to 0xFFFF and clears the LCP flag.
module hdlc_async_framer_top
    import hafr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hafr_in_if.sink     i_in,
    hafr_cfg_if.sink    i_cfg,
    hafr_out_if.source  o_out
);
    // Symbols travel from the sequencer to the escaper through this queue
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_sym sym_in;
    t_sym sym_out;

    // Front: hold each accepted payload beat and expand it into flag, header,
    // data, FCS and closing symbols; mark which ones need escaping
    hafr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_sym   (sym_in)
    );

    // Queue: lets the front run ahead while the line drains escape pairs
    hafr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_sym   (sym_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_sym   (sym_out),
        .o_empty (empty)
    );

    // Back: one line beat per cycle while the line is ready, escape pairs over two beats
    hafr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_sym   (sym_out),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule

### dv/hdlc_async_framer_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for hdlc_async_framer_top: drives payload beats and
// register writes, predicts each framed line beat and compares it at the output.
// Depends on hafr_pkg, the hafr_*_if interfaces and the framer RTL.
module hdlc_async_framer_top_test
    import hafr_pkg::*;
();

    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;
    // Cycles to let pass after the last expected line beat before a register
    // write or the end of the run: pipeline depth plus margin.
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 150;

    // One line beat as the predictor expects it
    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_last;
        logic       frame_done;
    } t_line_beat;

    logic clk;
    logic rst_n;

    hafr_in_if  payload_ch ();
    hafr_cfg_if cfg_ch ();
    hafr_out_if line_ch ();

    hdlc_async_framer_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (payload_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_out   (line_ch.source)
    );

    // ------------------------------------------------------------------
    // Framer predictor state: its own copy of the escape map, the header
    // mode, the running FCS and the latched LCP flag.
    // ------------------------------------------------------------------
    logic [63:0] esc_map_q [4];
    logic        cac_q;
    logic [15:0] fcs_q;
    logic        lcp_q;

    t_line_beat  expected_beats [$];
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;

    // Clock: 12 ns period
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Reflected CRC-16 over one byte, LSB first
    function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (r[0] ? FCS_POLY : 16'h0000);
        end
        return r;
    endfunction

    // Queue one byte, split into escape plus flipped byte when the map or
    // the LCP control-character rule asks for it.
    function automatic void push_escaped(input logic [7:0] b);
        logic needs_esc;
        needs_esc = (lcp_q && (b < ESC_XOR)) || esc_map_q[b[7:6]][b[5:0]];
        if (needs_esc) begin
            expected_beats.push_back('{ESC_BYTE, 1'b0, 1'b0});
            expected_beats.push_back('{b ^ ESC_XOR, 1'b0, 1'b0});
        end else begin
            expected_beats.push_back('{b, 1'b0, 1'b0});
        end
    endfunction

    // Fold a byte into the FCS and queue it escaped
    function automatic void push_counted(input logic [7:0] b);
        fcs_q = crc16_fold(fcs_q, b);
        push_escaped(b);
    endfunction

    // Work out every line beat that one accepted payload beat causes
    function automatic void predict_line_beats(input logic [7:0] b, input logic is_first,
                                               input logic is_last, input logic is_lcp);
        logic [15:0] fcs_out;
        t_line_beat  tail;
        if (is_first) begin
            // Restart the frame, even in the middle of one
            lcp_q = is_lcp;
            fcs_q = FCS_INIT;
            expected_beats.push_back('{FLAG_BYTE, 1'b0, 1'b0});
            if (lcp_q || !cac_q) begin
                push_counted(ADDR_BYTE);
                push_counted(CTRL_BYTE);
            end
        end
        push_counted(b);
        if (is_last) begin
            // Complemented FCS low byte first, then the closing flag (never escaped)
            fcs_out = fcs_q ^ FCS_INIT;
            push_escaped(fcs_out[7:0]);
            push_escaped(fcs_out[15:8]);
            expected_beats.push_back('{FLAG_BYTE, 1'b0, 1'b1});
            fcs_q = FCS_INIT;
        end
        // Mark the last line beat of this payload beat
        tail = expected_beats.pop_back();
        tail.run_last = 1'b1;
        expected_beats.push_back(tail);
    endfunction

    function automatic void report_mismatch(input string what, input t_line_beat exp_beat,
                                            input t_line_beat got_beat);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s: expected byte %h run_last %b frame_done %b, got byte %h run_last %b frame_done %b",
                     $realtime, what, exp_beat.line_byte, exp_beat.run_last, exp_beat.frame_done,
                     got_beat.line_byte, got_beat.run_last, got_beat.frame_done);
        end
    endfunction

    // Compare one accepted line beat against the oldest expectation
    function automatic void check_line_beat();
        t_line_beat got_beat;
        t_line_beat exp_beat;
        got_beat = '{line_ch.line_byte, line_ch.run_last, line_ch.frame_done};
        if (expected_beats.size() == 0) begin
            report_mismatch("unexpected line beat", '0, got_beat);
        end else begin
            exp_beat = expected_beats.pop_front();
            if (got_beat.line_byte !== exp_beat.line_byte) begin
                report_mismatch("line_byte mismatch", exp_beat, got_beat);
            end else if (got_beat.run_last !== exp_beat.run_last) begin
                report_mismatch("run_last mismatch", exp_beat, got_beat);
            end else if (got_beat.frame_done !== exp_beat.frame_done) begin
                report_mismatch("frame_done mismatch", exp_beat, got_beat);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: one process samples all three channels at each rising edge.
    // Predict before check so ordering inside the step never matters.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (t_cfg_idx'(cfg_ch.index))
                    CFG_MAP0: esc_map_q[0] = cfg_ch.data;
                    CFG_MAP1: esc_map_q[1] = cfg_ch.data;
                    CFG_MAP2: esc_map_q[2] = cfg_ch.data;
                    CFG_MAP3: esc_map_q[3] = cfg_ch.data;
                    CFG_CAC:  cac_q = cfg_ch.data[0];
                    default: ;
                endcase
            end
            if (payload_ch.valid && payload_ch.ready) begin
                predict_line_beats(payload_ch.payload_byte, payload_ch.frame_start,
                                   payload_ch.frame_end, payload_ch.is_lcp);
            end
            if (line_ch.valid && line_ch.ready) begin
                check_line_beat();
            end
        end
    end

    // Line side: stall at random at the current rate
    always @(posedge clk) begin
        line_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Watchdog: end a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------

    // Send one payload beat; idle first at the current sender rate, then
    // hold valid until the beat is taken. Valid stays high on return so a
    // back-to-back beat never lowers and raises it in the same step.
    task automatic send_payload(input logic [7:0] b, input logic is_first,
                                input logic is_last, input logic is_lcp);
        while ($urandom_range(99) < src_idle_pct) begin
            payload_ch.valid <= 1'b0;
            @(posedge clk);
        end
        payload_ch.valid        <= 1'b1;
        payload_ch.payload_byte <= b;
        payload_ch.frame_start  <= is_first;
        payload_ch.frame_end    <= is_last;
        payload_ch.is_lcp       <= is_lcp;
        do @(posedge clk); while (!payload_ch.ready);
    endtask

    // Drop valid, then wait until every expected line beat has come and the
    // pipeline has settled.
    task automatic wait_line_idle();
        payload_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; only called while the framer is idle
    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_maps(input logic [63:0] m0, input logic [63:0] m1,
                              input logic [63:0] m2, input logic [63:0] m3);
        write_reg(CFG_MAP0, m0);
        write_reg(CFG_MAP1, m1);
        write_reg(CFG_MAP2, m2);
        write_reg(CFG_MAP3, m3);
    endtask

    // Payload byte biased toward flag, escape and control characters
    function automatic logic [7:0] pick_payload();
        case ($urandom_range(7))
            0: return ESC_BYTE;
            1: return FLAG_BYTE;
            2: return 8'($urandom_range(31));
            3: return $urandom_range(1) ? 8'hFF : 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    // Well-formed frame of len beats with random content
    task automatic send_frame(input int len, input logic is_lcp);
        for (int k = 0; k < len; k++) begin
            send_payload(pick_payload(), k == 0, k == len - 1,
                         (k == 0) ? is_lcp : 1'($urandom_range(1)));
        end
    endtask

    // Mostly well-formed frames; the rest stray beats, lone ends, cut-off
    // frames and frames restarted midway.
    task automatic send_random_traffic(input int n_items);
        int sent;
        int kind;
        int len;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(99);
            if (kind < 75) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
                send_frame(len, 1'($urandom_range(1)));
                sent += len;
            end else if (kind < 85) begin
                // Stray beat outside a frame, sometimes carrying an end mark
                send_payload(8'($urandom), 1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
                sent += 1;
            end else if (kind < 93) begin
                // Cut-off frame: no end mark, the next start restarts it
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++) begin
                    send_payload(pick_payload(), k == 0, 1'b0, 1'($urandom_range(1)));
                end
                sent += len;
            end else begin
                // Restart inside a frame
                send_payload(pick_payload(), 1'b1, 1'b0, 1'($urandom_range(1)));
                send_payload(pick_payload(), 1'b0, 1'b0, 1'($urandom_range(1)));
                send_frame($urandom_range(1, 3), 1'($urandom_range(1)));
                sent += 3;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset map: flags, escapes and header bytes, stray beats, restarts
    task automatic test_basic_frames();
        // LCP single-beat frame with a control character
        send_payload(8'h00, 1'b1, 1'b1, 1'b1);
        // Non-LCP frame: flag, escape, top control char, all-ones
        send_payload(FLAG_BYTE, 1'b1, 1'b0, 1'b0);
        send_payload(ESC_BYTE, 1'b0, 1'b0, 1'b1);
        send_payload(8'h1F, 1'b0, 1'b0, 1'b0);
        send_payload(8'hFF, 1'b0, 1'b1, 1'b0);
        // Beat with no frame open
        send_payload(8'h20, 1'b0, 1'b0, 1'b1);
        // Restart inside a frame, switching to LCP
        send_payload(8'hC0, 1'b1, 1'b0, 1'b0);
        send_payload(8'h11, 1'b0, 1'b0, 1'b0);
        send_payload(8'h01, 1'b1, 1'b0, 1'b1);
        send_payload(FLAG_BYTE, 1'b0, 1'b1, 1'b0);
        wait_line_idle();
    endtask

    // Address/control compression: dropped on non-LCP, kept on LCP
    task automatic test_header_compression();
        write_reg(CFG_CAC, 64'd1);
        send_payload(8'h21, 1'b1, 1'b0, 1'b0);
        send_payload(8'h80, 1'b0, 1'b1, 1'b0);
        send_payload(8'h05, 1'b1, 1'b1, 1'b1);
        wait_line_idle();
        write_reg(CFG_CAC, 64'd0);
    endtask

    // Map extremes: escape everything, then nothing but the LCP rule
    task automatic test_escape_maps();
        write_maps('1, '1, '1, '1);
        send_payload(8'h41, 1'b1, 1'b1, 1'b0);
        send_payload(8'hAA, 1'b1, 1'b1, 1'b1);
        wait_line_idle();
        write_maps('0, '0, '0, '0);
        send_payload(FLAG_BYTE, 1'b1, 1'b0, 1'b0);
        send_payload(ESC_BYTE, 1'b0, 1'b0, 1'b0);
        send_payload(8'h00, 1'b0, 1'b1, 1'b0);
        send_payload(8'h1F, 1'b1, 1'b1, 1'b1);
        wait_line_idle();
        write_maps(MAP0_RESET, MAP1_RESET, MAP2_RESET, MAP3_RESET);
    endtask

    // One random phase: set idling rates and config, send, drain.
    // The sender-idle phase also pauses midway until the line side is empty.
    task automatic test_random_phase(input int src_pct, input int snk_pct,
                                     input int map_mode, input logic cac);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        case (map_mode)
            0: write_maps(MAP0_RESET, MAP1_RESET, MAP2_RESET, MAP3_RESET);
            1: write_maps({$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom});
            2: write_maps('0, '0, '0, '0);
            default: write_maps('1, MAP1_RESET, '1, {$urandom, $urandom});
        endcase
        write_reg(CFG_CAC, {63'd0, cac});
        if (src_pct != 0 && snk_pct == 0) begin
            send_random_traffic(RANDOM_ITEMS / 8);
            wait_line_idle();
            send_random_traffic(RANDOM_ITEMS / 8);
        end else begin
            send_random_traffic(RANDOM_ITEMS / 4);
        end
        wait_line_idle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Predictor at reset values
        esc_map_q[0]   = MAP0_RESET;
        esc_map_q[1]   = MAP1_RESET;
        esc_map_q[2]   = MAP2_RESET;
        esc_map_q[3]   = MAP3_RESET;
        cac_q          = 1'b0;
        fcs_q          = FCS_INIT;
        lcp_q          = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;

        // Drive every input to a known value and hold reset
        rst_n                   <= 1'b0;
        payload_ch.valid        <= 1'b0;
        payload_ch.payload_byte <= '0;
        payload_ch.frame_start  <= 1'b0;
        payload_ch.frame_end    <= 1'b0;
        payload_ch.is_lcp       <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= CFG_MAP0;
        cfg_ch.data             <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with no idling
        test_basic_frames();
        test_header_compression();
        test_escape_maps();

        // Random part: no idling, sender idle, line stalls, both
        test_random_phase(0, 0, 0, 1'($urandom_range(1)));
        test_random_phase(57, 0, 1, 1'b1);
        test_random_phase(0, 57, 2, 1'b0);
        test_random_phase(17, 17, 3, 1'($urandom_range(1)));

        wait_line_idle();
        if (mismatch_count == 0 && expected_beats.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
